>>> design/lne_pkg.sv
// ----------------------------------------------------------------------------
// lne_pkg
// shared types and constants of the learned noise expander
// ----------------------------------------------------------------------------
`default_nettype none

package lne_pkg;

    // default parameter values
    localparam int MAX_LEARN_COUNT_DEF = 65536;
    localparam int SAMPLE_BITS_DEF     = 24;

    // opcode carried in the input tuser
    localparam int              OP_W       = 2;
    localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

    // configuration register map
    localparam int                    CFG_ADDR_W   = 2;
    localparam int                    CFG_DATA_W   = 23;
    localparam logic [CFG_ADDR_W-1:0] CFG_BYPASS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMOUNT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_THR = 2'd2;

    // gain, Q23
    localparam int                 GAIN_W    = 24;
    localparam int                 GAIN_FRAC = 23;
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 24'h800000;

    // threshold, 23-bit linear magnitude
    localparam int                 THR_W        = 23;
    localparam logic [THR_W-1:0]   THR_MAX      = 23'h7FFFFF;
    localparam logic [THR_W-1:0]   BASE_THR_RST = 23'd8389;

    // reduction amount, Q16, and the 0.85 depth scale in Q23
    localparam int                 AMT_W     = 17;
    localparam logic [AMT_W-1:0]   AMT_ONE   = 17'h10000;
    localparam int                 AMT_SHIFT = 16;
    localparam logic [THR_W-1:0]   DEPTH_K   = 23'd7130317;

    // smoothing coefficients, Q20
    localparam int                 COEF_W     = 15;
    localparam logic [COEF_W-1:0]  COEF_DOWN  = 15'd31457;
    localparam logic [COEF_W-1:0]  COEF_UP    = 15'd6291;
    localparam int                 COEF_SHIFT = 20;

    // learned magnitude sum
    localparam int                 SUM_W = 40;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEPTH,
        ST_DIV,
        ST_DIV_WAIT,
        ST_SMOOTH,
        ST_GAIN,
        ST_OUT_MUL,
        ST_OUT,
        ST_EMIT,
        ST_FIN_WAIT
    } lne_state_t;

endpackage

`default_nettype wire

>>> design/lne_div.sv
// ----------------------------------------------------------------------------
// lne_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lne_div #(
    parameter int N_W = 56,
    parameter int D_W = 23
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic      [N_W-1:0] quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]   q_reg,    q_next;
    logic [D_W-1:0]   r_reg,    r_next;
    logic [D_W-1:0]   dv_reg,   dv_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [D_W:0]     shifted;
    logic [D_W:0]     trial;
    logic             fits;

    always_comb begin
        shifted   = {r_reg, q_reg[N_W-1]};
        trial     = shifted - {1'b0, dv_reg};
        fits      = shifted >= {1'b0, dv_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            dv_next   = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when the divisor fits
            q_next = {q_reg[N_W-2:0], fits};
            r_next = fits ? trial[D_W-1:0] : shifted[D_W-1:0];
            if (cnt_reg == CNT_W'(N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        dv_reg <= dv_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> design/learned_noise_expander_top.sv
// ----------------------------------------------------------------------------
// learned_noise_expander_top
// downward noise expander with a learned threshold on signed audio samples
// ----------------------------------------------------------------------------
// Each input beat carries a sample in tdata and an opcode in tuser: 0 processes
// the sample and returns one output beat, 1 adds the sample magnitude to the
// noise estimate, 2 closes the estimate and raises the learned threshold to
// 1.5 times the mean magnitude (opcode 3 does nothing). Samples below the
// threshold, the larger of base_threshold and the learned one, are pulled
// toward a floor set by reduction_amount with a smoothed gain. The block
// handles one beat at a time and holds s_tready low until that beat is done;
// a processed sample below the threshold and a finish beat with samples both
// wait on the divider, and a processed sample skips the gain update when the
// gain is already on target. The divider is one shared restoring unit taking
// one quotient bit per cycle over max(SAMPLE_BITS, 24)+24 bits; a single
// shared multiplier does every product, one per cycle with its result
// registered. An output register sits on the master side, so a new beat is
// taken while the previous result still waits for m_tready; a result that
// finds that register still full holds the block until m_tready frees it.
// Configuration writes are applied at once and are meant to happen only while
// the block is idle; writing base_threshold also clears the learned threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module learned_noise_expander_top #(
    parameter int MAX_LEARN_COUNT = lne_pkg::MAX_LEARN_COUNT_DEF,
    parameter int SAMPLE_BITS     = lne_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input beats
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [TDATA_W-1:0]              s_tdata,   // sample_in
    input  wire logic [lne_pkg::OP_W-1:0]        s_tuser,   // opcode
    // result beats
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [TDATA_W-1:0]              m_tdata,   // sample_out
    // register writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [lne_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [lne_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // operand and product widths of the shared multiplier
    localparam int A_W     = (SAMPLE_BITS > lne_pkg::GAIN_W) ? SAMPLE_BITS : lne_pkg::GAIN_W;
    localparam int MUL_W   = A_W + lne_pkg::GAIN_W;
    localparam int Y_W     = MUL_W - lne_pkg::GAIN_FRAC;
    localparam int CNT_W   = $clog2(MAX_LEARN_COUNT + 1);
    localparam int DIV_D_W = (CNT_W + 1 > lne_pkg::THR_W) ? CNT_W + 1 : lne_pkg::THR_W;
    localparam int SUM3_W  = lne_pkg::SUM_W + 2;

    localparam logic [MUL_W-1:0] STEP_RND = (MUL_W'(1) << lne_pkg::COEF_SHIFT) - MUL_W'(1);
    localparam logic [MUL_W-1:0] OUT_RND  = MUL_W'(1) << (lne_pkg::GAIN_FRAC - 1);
    localparam logic [Y_W-1:0]   LIM_NEG  = Y_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [Y_W-1:0]   LIM_POS  = LIM_NEG - Y_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LEARN_COUNT);

    // control and model state
    lne_pkg::lne_state_t            state_reg,    state_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           bypass_reg,   bypass_next;
    logic [lne_pkg::AMT_W-1:0]      amount_reg,   amount_next;
    logic [lne_pkg::THR_W-1:0]      base_thr_reg, base_thr_next;
    logic [lne_pkg::THR_W-1:0]      learned_reg,  learned_next;
    logic [lne_pkg::GAIN_W-1:0]     gain_reg,     gain_next;
    logic [lne_pkg::SUM_W-1:0]      sum_reg,      sum_next;
    logic [CNT_W-1:0]               count_reg,    count_next;
    logic                           learning_reg, learning_next;

    // per-beat payload
    logic [lne_pkg::OP_W-1:0]       op_reg,       op_next;
    logic [SAMPLE_BITS-1:0]         sample_reg,   sample_next;
    logic [A_W-1:0]                 mag_reg,      mag_next;
    logic                           neg_reg,      neg_next;
    logic [MUL_W-1:0]               prod_reg,     prod_next;
    logic [lne_pkg::THR_W-1:0]      depth_reg,    depth_next;
    logic [lne_pkg::GAIN_W-1:0]     target_reg,   target_next;
    logic                           down_reg,     down_next;
    logic [SAMPLE_BITS-1:0]         res_reg,      res_next;
    logic [TDATA_W-1:0]             m_tdata_reg,  m_tdata_next;

    // shared multiplier
    logic [A_W-1:0]                 mul_a;
    logic [lne_pkg::GAIN_W-1:0]     mul_b;
    logic [MUL_W-1:0]               mul_res;
    logic                           mul_en;

    // shared divider
    logic                           div_start;
    logic [MUL_W-1:0]               div_dividend;
    logic [DIV_D_W-1:0]             div_divisor;
    logic                           div_done;
    logic [MUL_W-1:0]               div_quo;

    // datapath helpers
    logic [SAMPLE_BITS-1:0]         in_sample;
    logic [SAMPLE_BITS-1:0]         in_mag;
    logic [lne_pkg::THR_W-1:0]      thr;
    logic [lne_pkg::AMT_W-1:0]      amt_c;
    logic [lne_pkg::SUM_W:0]        sum_add;
    logic [SUM3_W-1:0]              sum3;
    logic [MUL_W-1:0]               step_sum;
    logic [lne_pkg::GAIN_W-1:0]     step;
    logic [MUL_W-1:0]               out_sum;
    logic [Y_W-1:0]                 y_mag;
    logic [Y_W-1:0]                 y_sat;
    logic [lne_pkg::THR_W-1:0]      mean15;

    assign mul_res = mul_a * mul_b;

    lne_div #(
        .N_W (MUL_W),
        .D_W (DIV_D_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sample magnitude, the most negative sample maps to 2^(SAMPLE_BITS-1)
    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_mag    = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;

    // effective threshold and clamped amount
    assign thr   = (base_thr_reg > learned_reg) ? base_thr_reg : learned_reg;
    assign amt_c = (amount_reg > lne_pkg::AMT_ONE) ? lne_pkg::AMT_ONE : amount_reg;

    // learn accumulation and finish dividend 3 * sum
    assign sum_add = {1'b0, sum_reg} + (lne_pkg::SUM_W + 1)'(mag_reg);
    assign sum3    = SUM3_W'(sum_reg) + SUM3_W'({sum_reg, 1'b0});

    // gain step, rounded up
    assign step_sum = prod_reg + STEP_RND;
    assign step     = step_sum[lne_pkg::COEF_SHIFT +: lne_pkg::GAIN_W];

    // output magnitude, rounded to nearest and saturated per sign
    assign out_sum = prod_reg + OUT_RND;
    assign y_mag   = out_sum[MUL_W-1:lne_pkg::GAIN_FRAC];
    assign y_sat   = neg_reg ? ((y_mag > LIM_NEG) ? LIM_NEG : y_mag)
                             : ((y_mag > LIM_POS) ? LIM_POS : y_mag);

    // saturated learned mean times 1.5
    assign mean15 = (div_quo > MUL_W'(lne_pkg::THR_MAX)) ? lne_pkg::THR_MAX
                                                          : div_quo[lne_pkg::THR_W-1:0];

    assign s_tready = (state_reg == lne_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        bypass_next   = bypass_reg;
        amount_next   = amount_reg;
        base_thr_next = base_thr_reg;
        learned_next  = learned_reg;
        gain_next     = gain_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        learning_next = learning_reg;
        op_next       = op_reg;
        sample_next   = sample_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        depth_next    = depth_reg;
        target_next   = target_reg;
        down_next     = down_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        mul_a         = mag_reg;
        mul_b         = gain_reg;
        mul_en        = 1'b0;
        div_start     = 1'b0;
        div_dividend  = prod_reg;
        div_divisor   = DIV_D_W'(thr);

        // result beat taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // register writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                lne_pkg::CFG_BYPASS: begin
                    bypass_next = cfg_wdata[0];
                end
                lne_pkg::CFG_AMOUNT: begin
                    amount_next = cfg_wdata[lne_pkg::AMT_W-1:0];
                end
                lne_pkg::CFG_BASE_THR: begin
                    base_thr_next = cfg_wdata[lne_pkg::THR_W-1:0];
                    learned_next  = '0;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            lne_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    sample_next = in_sample;
                    mag_next    = A_W'(in_mag);
                    neg_next    = in_sample[SAMPLE_BITS-1];
                    state_next  = lne_pkg::ST_DECODE;
                end
            end
            lne_pkg::ST_DECODE: begin
                case (op_reg)
                    lne_pkg::OP_LEARN: begin
                        learning_next = 1'b1;
                        sum_next      = sum_add[lne_pkg::SUM_W] ? '1
                                                                : sum_add[lne_pkg::SUM_W-1:0];
                        if (count_reg < CNT_MAX) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = lne_pkg::ST_IDLE;
                    end
                    lne_pkg::OP_FINISH: begin
                        if (count_reg != '0) begin
                            div_start    = 1'b1;
                            div_dividend = MUL_W'(sum3);
                            div_divisor  = DIV_D_W'({count_reg, 1'b0});
                            state_next   = lne_pkg::ST_FIN_WAIT;
                        end else begin
                            sum_next      = '0;
                            learning_next = 1'b0;
                            state_next    = lne_pkg::ST_IDLE;
                        end
                    end
                    lne_pkg::OP_PROCESS: begin
                        if (bypass_reg || learning_reg) begin
                            res_next   = sample_reg;
                            state_next = lne_pkg::ST_EMIT;
                        end else if (mag_reg < A_W'(thr)) begin
                            // depth = amount * 0.85, first product
                            mul_a      = A_W'(amt_c);
                            mul_b      = lne_pkg::GAIN_W'(lne_pkg::DEPTH_K);
                            mul_en     = 1'b1;
                            state_next = lne_pkg::ST_DEPTH;
                        end else begin
                            target_next = lne_pkg::GAIN_ONE;
                            state_next  = lne_pkg::ST_SMOOTH;
                        end
                    end
                    default: begin
                        state_next = lne_pkg::ST_IDLE;
                    end
                endcase
            end
            lne_pkg::ST_DEPTH: begin
                // depth * |x|, divided by the threshold next
                depth_next = prod_reg[lne_pkg::AMT_SHIFT +: lne_pkg::THR_W];
                mul_a      = mag_reg;
                mul_b      = lne_pkg::GAIN_W'(prod_reg[lne_pkg::AMT_SHIFT +: lne_pkg::THR_W]);
                mul_en     = 1'b1;
                state_next = lne_pkg::ST_DIV;
            end
            lne_pkg::ST_DIV: begin
                div_start  = 1'b1;
                state_next = lne_pkg::ST_DIV_WAIT;
            end
            lne_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    target_next = lne_pkg::GAIN_ONE - lne_pkg::GAIN_W'(depth_reg)
                                + lne_pkg::GAIN_W'(div_quo[lne_pkg::THR_W-1:0]);
                    state_next  = lne_pkg::ST_SMOOTH;
                end
            end
            lne_pkg::ST_SMOOTH: begin
                if (target_reg < gain_reg) begin
                    down_next  = 1'b1;
                    mul_a      = A_W'(gain_reg - target_reg);
                    mul_b      = lne_pkg::GAIN_W'(lne_pkg::COEF_DOWN);
                    mul_en     = 1'b1;
                    state_next = lne_pkg::ST_GAIN;
                end else if (target_reg > gain_reg) begin
                    down_next  = 1'b0;
                    mul_a      = A_W'(target_reg - gain_reg);
                    mul_b      = lne_pkg::GAIN_W'(lne_pkg::COEF_UP);
                    mul_en     = 1'b1;
                    state_next = lne_pkg::ST_GAIN;
                end else begin
                    // gain already on target, go straight to the output product
                    mul_en     = 1'b1;
                    state_next = lne_pkg::ST_OUT;
                end
            end
            lne_pkg::ST_GAIN: begin
                gain_next  = down_reg ? (gain_reg - step) : (gain_reg + step);
                state_next = lne_pkg::ST_OUT_MUL;
            end
            lne_pkg::ST_OUT_MUL: begin
                mul_en     = 1'b1;
                state_next = lne_pkg::ST_OUT;
            end
            lne_pkg::ST_OUT: begin
                res_next   = neg_reg ? (~y_sat[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                                     : y_sat[SAMPLE_BITS-1:0];
                state_next = lne_pkg::ST_EMIT;
            end
            lne_pkg::ST_EMIT: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'(res_reg);
                    state_next    = lne_pkg::ST_IDLE;
                end
            end
            lne_pkg::ST_FIN_WAIT: begin
                if (div_done) begin
                    if (mean15 > learned_reg) begin
                        learned_next = mean15;
                    end
                    sum_next      = '0;
                    count_next    = '0;
                    learning_next = 1'b0;
                    state_next    = lne_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lne_pkg::ST_IDLE;
            end
        endcase

        if (count_next != count_reg && state_reg == lne_pkg::ST_DECODE
                && op_reg == lne_pkg::OP_FINISH) begin
            count_next = '0;
        end
        if (state_reg == lne_pkg::ST_DECODE && op_reg == lne_pkg::OP_FINISH
                && count_reg == '0) begin
            count_next = '0;
        end
    end

    assign prod_next = mul_en ? mul_res : prod_reg;

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lne_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            bypass_reg   <= 1'b0;
            amount_reg   <= '0;
            base_thr_reg <= lne_pkg::BASE_THR_RST;
            learned_reg  <= '0;
            gain_reg     <= lne_pkg::GAIN_ONE;
            sum_reg      <= '0;
            count_reg    <= '0;
            learning_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            bypass_reg   <= bypass_next;
            amount_reg   <= amount_next;
            base_thr_reg <= base_thr_next;
            learned_reg  <= learned_next;
            gain_reg     <= gain_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            learning_reg <= learning_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        sample_reg  <= sample_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        depth_reg   <= depth_next;
        target_reg  <= target_next;
        down_reg    <= down_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
